FILE: rtl/msched_pkg.sv
// Package for the multirate frame scheduler.
// Holds the configuration register map, reset values and result codes.
// No dependencies.
`default_nettype none

package msched_pkg;

    // Configuration registers are all 16 bits wide.
    localparam int CFG_W     = 16;
    localparam int NUM_CFG   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_RATES = 6;
    localparam int NUM_AXES  = 3;
    localparam int NUM_SUMS  = 9;

    // Register index map of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT = 3'd0,
        CFG_DIV_FAST    = 3'd1,
        CFG_DIV_MEDIUM  = 3'd2,
        CFG_DIV_FIFTY   = 3'd3,
        CFG_DIV_TEN     = 3'd4,
        CFG_DIV_FIVE    = 3'd5,
        CFG_DIV_ONE     = 3'd6
    } cfg_idx_t;

    // Rate slots: bit position in frame_flags and divisor slot.
    localparam int RATE_FAST   = 0;
    localparam int RATE_MEDIUM = 1;
    localparam int RATE_FIFTY  = 2;
    localparam int RATE_TEN    = 3;
    localparam int RATE_FIVE   = 4;
    localparam int RATE_ONE    = 5;

    // Running and latched sum slots.
    localparam int SUM_FAST_ACCEL = 0;
    localparam int SUM_FAST_GYRO  = 3;
    localparam int SUM_SLOW_ACCEL = 6;

    // Barometer action codes.
    typedef enum logic [1:0] {
        BARO_NONE     = 2'd0,
        BARO_READ_TMP = 2'd1,
        BARO_READ_PRS = 2'd2
    } baro_action_t;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] DIV_RESET [NUM_RATES] =
        '{16'd2, 16'd10, 16'd20, 16'd100, 16'd200, 16'd1000};

endpackage

`default_nettype wire

FILE: rtl/msched_if.sv
// Handshake interfaces of the multirate frame scheduler: tick requests in,
// result requests out. Uses msched_pkg for the number of rates.
`default_nettype none

interface msched_tick_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          run_enable;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] gyro_roll;
    logic signed [SAMPLE_BITS-1:0] gyro_pitch;
    logic signed [SAMPLE_BITS-1:0] gyro_yaw;
    logic                          temperature_pending;

    modport source (
        output valid, run_enable, accel_x, accel_y, accel_z,
               gyro_roll, gyro_pitch, gyro_yaw, temperature_pending,
        input  ready
    );
    modport sink (
        input  valid, run_enable, accel_x, accel_y, accel_z,
               gyro_roll, gyro_pitch, gyro_yaw, temperature_pending,
        output ready
    );
endinterface

interface msched_result_if
    import msched_pkg::*;
#(
    parameter int SUM_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic [NUM_RATES-1:0]       frame_flags;
    logic [1:0]                 baro_action;
    logic                       mag_request;
    logic signed [SUM_BITS-1:0] fast_accel_x;
    logic signed [SUM_BITS-1:0] fast_accel_y;
    logic signed [SUM_BITS-1:0] fast_accel_z;
    logic signed [SUM_BITS-1:0] fast_gyro_roll;
    logic signed [SUM_BITS-1:0] fast_gyro_pitch;
    logic signed [SUM_BITS-1:0] fast_gyro_yaw;
    logic signed [SUM_BITS-1:0] slow_accel_x;
    logic signed [SUM_BITS-1:0] slow_accel_y;
    logic signed [SUM_BITS-1:0] slow_accel_z;

    modport source (
        output valid, frame_flags, baro_action, mag_request,
               fast_accel_x, fast_accel_y, fast_accel_z,
               fast_gyro_roll, fast_gyro_pitch, fast_gyro_yaw,
               slow_accel_x, slow_accel_y, slow_accel_z,
        input  ready
    );
    modport sink (
        input  valid, frame_flags, baro_action, mag_request,
               fast_accel_x, fast_accel_y, fast_accel_z,
               fast_gyro_roll, fast_gyro_pitch, fast_gyro_yaw,
               slow_accel_x, slow_accel_y, slow_accel_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/multirate_frame_scheduler.sv
// Multirate frame scheduler top level: tick input register, frame and
// rate remainder update, saturating sums, and result register.
// Depends on msched_pkg and the interfaces in msched_if.sv.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+-----------------------------------
//   tick     | in  | valid / ready     | run enable, 6 samples, temp flag
//   result   | out | valid / ready     | flags, baro action, mag, 9 sums
//   cfg      | in  | cfg_write, no ack | cfg_index, cfg_data (16 bits)
//
// One tick request is taken every cycle while no result stall holds the
// input register; its result request passes through the input register,
// then the result register.
// The frame position, remainder and sum update is combinational, in the
// stage between the input register and the result register.
// Reset clears the frame position, remainders and all sums, and loads the
// configuration reset values. A stalled result holds the input register,
// which then holds tick ready low until the result is taken.
`default_nettype none

module multirate_frame_scheduler
    import msched_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int SUM_BITS     = 24,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    msched_tick_if.sink               tick,
    msched_result_if.source           result,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // Compare width covers both the counter and the 16-bit registers,
    // plus one bit for the increment.
    localparam int CMP_W = ((COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W) + 1;
    // Add width covers both the sample and the sum, plus a carry bit.
    localparam int ADD_W = ((SUM_BITS > SAMPLE_BITS) ? SUM_BITS : SAMPLE_BITS) + 1;
    localparam logic signed [ADD_W-1:0] SAT_HI =
        {{(ADD_W-SUM_BITS+1){1'b0}}, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [ADD_W-1:0] SAT_LO =
        {{(ADD_W-SUM_BITS+1){1'b1}}, {(SUM_BITS-1){1'b0}}};

    // Configuration registers.
    logic [CFG_W-1:0] frame_count_reg;
    logic [CFG_W-1:0] div_reg [NUM_RATES];

    // Input register stage.
    logic                          in_valid_reg;
    logic                          in_run_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg [2*NUM_AXES];
    logic                          in_temp_reg;

    // Scheduler state.
    logic [COUNTER_BITS-1:0] frame_pos_reg, frame_pos_next;
    logic [COUNTER_BITS-1:0] rem_reg  [NUM_RATES];
    logic [COUNTER_BITS-1:0] rem_next [NUM_RATES];
    logic signed [SUM_BITS-1:0] run_sum_reg  [NUM_SUMS];
    logic signed [SUM_BITS-1:0] run_sum_next [NUM_SUMS];
    logic signed [SUM_BITS-1:0] lat_sum_reg  [NUM_SUMS];
    logic signed [SUM_BITS-1:0] lat_sum_next [NUM_SUMS];

    // Result register stage.
    logic                 out_valid_reg;
    logic [NUM_RATES-1:0] flags_reg, flags_next;
    baro_action_t         baro_reg, baro_next;
    logic                 mag_reg, mag_next;

    // Handshake control.
    logic stage_advance;
    logic tick_take;

    // Combinational helpers.
    logic [CMP_W-1:0]       pos_inc;
    logic                   wrap;
    logic [CMP_W-1:0]       eff_div [NUM_RATES];
    logic [CMP_W-1:0]       rem_inc [NUM_RATES];
    logic [CMP_W-1:0]       rem_new [NUM_RATES];
    logic signed [SAMPLE_BITS-1:0] sum_src [NUM_SUMS];
    logic signed [ADD_W-1:0] sum_wide [NUM_SUMS];
    logic signed [SUM_BITS-1:0] sum_sat [NUM_SUMS];

    // Stage 2 moves when the input register holds a tick and the result register is empty or being drained.
    assign stage_advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready    = !in_valid_reg || stage_advance;
    assign tick_take     = tick.valid && tick.ready;

    // Frame position step and wrap.
    always_comb
    begin
        pos_inc = {{(CMP_W-COUNTER_BITS){1'b0}}, frame_pos_reg} + 1'b1;
        wrap    = (pos_inc > {{(CMP_W-CFG_W){1'b0}}, frame_count_reg})
                  || pos_inc[COUNTER_BITS];
        frame_pos_next = wrap ? {{(COUNTER_BITS-1){1'b0}}, 1'b1}
                              : pos_inc[COUNTER_BITS-1:0];
    end

    // Per-rate remainders, each stepped alongside the frame position.
    always_comb
    begin
        for (int i = 0; i < NUM_RATES; i++)
        begin
            eff_div[i] = (div_reg[i] == '0) ? {{(CMP_W-1){1'b0}}, 1'b1}
                                            : {{(CMP_W-CFG_W){1'b0}}, div_reg[i]};
            rem_inc[i] = {{(CMP_W-COUNTER_BITS){1'b0}}, rem_reg[i]} + 1'b1;
            if (wrap)
                rem_new[i] = (eff_div[i] == {{(CMP_W-1){1'b0}}, 1'b1})
                             ? '0 : {{(CMP_W-1){1'b0}}, 1'b1};
            else
                rem_new[i] = (rem_inc[i] >= eff_div[i]) ? '0 : rem_inc[i];
            rem_next[i]   = rem_new[i][COUNTER_BITS-1:0];
            flags_next[i] = in_run_reg && (rem_next[i] == '0);
        end
    end

    // Magnetometer request one tick ahead of the ten boundary.
    assign mag_next = in_run_reg
        && ({{(CMP_W-COUNTER_BITS){1'b0}}, rem_next[RATE_TEN]}
            == (eff_div[RATE_TEN] - 1'b1));

    // Barometer action on the medium boundary.
    always_comb
    begin
        if (flags_next[RATE_MEDIUM])
            baro_next = in_temp_reg ? BARO_READ_PRS : BARO_READ_TMP;
        else
            baro_next = BARO_NONE;
    end

    // Saturating accumulation, then latch and clear on boundaries.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum_src[SUM_FAST_ACCEL + a] = in_sample_reg[a];
            sum_src[SUM_FAST_GYRO + a]  = in_sample_reg[NUM_AXES + a];
            sum_src[SUM_SLOW_ACCEL + a] = in_sample_reg[a];
        end
        for (int s = 0; s < NUM_SUMS; s++)
        begin
            sum_wide[s] =
                {{(ADD_W-SUM_BITS){run_sum_reg[s][SUM_BITS-1]}}, run_sum_reg[s]}
                + {{(ADD_W-SAMPLE_BITS){sum_src[s][SAMPLE_BITS-1]}}, sum_src[s]};
            if (sum_wide[s] > SAT_HI)
                sum_sat[s] = SAT_HI[SUM_BITS-1:0];
            else if (sum_wide[s] < SAT_LO)
                sum_sat[s] = SAT_LO[SUM_BITS-1:0];
            else
                sum_sat[s] = sum_wide[s][SUM_BITS-1:0];
            lat_sum_next[s] = lat_sum_reg[s];
            run_sum_next[s] = sum_sat[s];
            if ((s < SUM_SLOW_ACCEL) ? flags_next[RATE_FAST] : flags_next[RATE_MEDIUM])
            begin
                lat_sum_next[s] = sum_sat[s];
                run_sum_next[s] = '0;
            end
        end
    end

    // Configuration, state and valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= FRAME_COUNT_RESET;
            for (int i = 0; i < NUM_RATES; i++)
            begin
                div_reg[i] <= DIV_RESET[i];
                rem_reg[i] <= '0;
            end
            for (int s = 0; s < NUM_SUMS; s++)
            begin
                run_sum_reg[s] <= '0;
                lat_sum_reg[s] <= '0;
            end
            frame_pos_reg <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes; indexes past the map are ignored.
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FRAME_COUNT: frame_count_reg      <= cfg_data;
                    CFG_DIV_FAST:    div_reg[RATE_FAST]   <= cfg_data;
                    CFG_DIV_MEDIUM:  div_reg[RATE_MEDIUM] <= cfg_data;
                    CFG_DIV_FIFTY:   div_reg[RATE_FIFTY]  <= cfg_data;
                    CFG_DIV_TEN:     div_reg[RATE_TEN]    <= cfg_data;
                    CFG_DIV_FIVE:    div_reg[RATE_FIVE]   <= cfg_data;
                    CFG_DIV_ONE:     div_reg[RATE_ONE]    <= cfg_data;
                    default:         frame_count_reg      <= frame_count_reg;
                endcase
            end

            // Input register stage.
            if (tick.ready)
                in_valid_reg <= tick.valid;

            // State update and result load happen together.
            if (stage_advance && in_run_reg)
            begin
                frame_pos_reg <= frame_pos_next;
                for (int i = 0; i < NUM_RATES; i++)
                    rem_reg[i] <= rem_next[i];
                for (int s = 0; s < NUM_SUMS; s++)
                begin
                    run_sum_reg[s] <= run_sum_next[s];
                    lat_sum_reg[s] <= lat_sum_next[s];
                end
            end

            if (stage_advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            in_run_reg       <= tick.run_enable;
            in_sample_reg[0] <= tick.accel_x;
            in_sample_reg[1] <= tick.accel_y;
            in_sample_reg[2] <= tick.accel_z;
            in_sample_reg[3] <= tick.gyro_roll;
            in_sample_reg[4] <= tick.gyro_pitch;
            in_sample_reg[5] <= tick.gyro_yaw;
            in_temp_reg      <= tick.temperature_pending;
        end
        if (stage_advance)
        begin
            flags_reg <= flags_next;
            baro_reg  <= baro_next;
            mag_reg   <= mag_next;
        end
    end

    // Latched sums only change when a new result is loaded.
    assign result.valid           = out_valid_reg;
    assign result.frame_flags     = flags_reg;
    assign result.baro_action     = baro_reg;
    assign result.mag_request     = mag_reg;
    assign result.fast_accel_x    = lat_sum_reg[SUM_FAST_ACCEL];
    assign result.fast_accel_y    = lat_sum_reg[SUM_FAST_ACCEL + 1];
    assign result.fast_accel_z    = lat_sum_reg[SUM_FAST_ACCEL + 2];
    assign result.fast_gyro_roll  = lat_sum_reg[SUM_FAST_GYRO];
    assign result.fast_gyro_pitch = lat_sum_reg[SUM_FAST_GYRO + 1];
    assign result.fast_gyro_yaw   = lat_sum_reg[SUM_FAST_GYRO + 2];
    assign result.slow_accel_x    = lat_sum_reg[SUM_SLOW_ACCEL];
    assign result.slow_accel_y    = lat_sum_reg[SUM_SLOW_ACCEL + 1];
    assign result.slow_accel_z    = lat_sum_reg[SUM_SLOW_ACCEL + 2];

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the multirate frame scheduler.
// Drives tick requests and checks every result request against a cycle-free
// predictor of the scheduler. Depends on msched_pkg, msched_if.sv and the RTL top.
`default_nettype none

module testbench;
    import msched_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 24;
    localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // One tick request: samples are accel x, y, z then gyro roll, pitch, yaw.
    typedef struct packed {
        logic                           run;
        logic [5:0][SAMPLE_W-1:0]       smp;
        logic                           temp;
    } tick_req_t;

    // One scheduler result, with the sums in latched-sum slot order.
    typedef struct packed {
        logic [NUM_RATES-1:0]           flags;
        baro_action_t                   baro;
        logic                           mag;
        logic [NUM_SUMS-1:0][SUM_W-1:0] sums;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    msched_tick_if #(.SAMPLE_BITS(SAMPLE_W)) tick_bus ();
    msched_result_if #(.SUM_BITS(SUM_W)) res_bus ();

    multirate_frame_scheduler #(
        .SAMPLE_BITS  (SAMPLE_W),
        .SUM_BITS     (SUM_W),
        .COUNTER_BITS (16)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_bus),
        .result    (res_bus),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: configuration copy, frame position, remainders and sums.
    logic [CFG_W-1:0]        cfg_shadow [NUM_CFG];
    logic [15:0]             frame_pos;
    logic [15:0]             rate_rem [NUM_RATES];
    logic signed [SUM_W-1:0] run_sum [NUM_SUMS];
    logic signed [SUM_W-1:0] latch_sum [NUM_SUMS];

    tick_req_t     tick_backlog [$];
    sched_result_t expected_results [$];
    int            mismatch_count = 0;
    int            results_seen = 0;
    logic          tick_fired = 1'b0;
    logic          steady = 1'b0;

    string sum_label [NUM_SUMS] = '{"fast_accel_x", "fast_accel_y", "fast_accel_z",
                                    "fast_gyro_roll", "fast_gyro_pitch", "fast_gyro_yaw",
                                    "slow_accel_x", "slow_accel_y", "slow_accel_z"};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A divisor of zero behaves as one.
    function automatic logic [16:0] eff_divisor(int rate);
        logic [16:0] d;
        d = {1'b0, cfg_shadow[CFG_DIV_FAST + rate]};
        return (d == 17'd0) ? 17'd1 : d;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(logic signed [SUM_W-1:0] acc,
                                                        logic signed [SAMPLE_W-1:0] smp);
        longint s;
        s = longint'(acc) + longint'(smp);
        if (s > SUM_MAX)
            s = SUM_MAX;
        if (s < SUM_MIN)
            s = SUM_MIN;
        return s[SUM_W-1:0];
    endfunction

    // Advance the schedule by one tick and return the result it produces.
    function automatic sched_result_t advance_schedule(tick_req_t t);
        sched_result_t r;
        logic [16:0]   next_pos;
        logic [16:0]   div_eff;
        logic [16:0]   rem_next;
        logic          wrapped;
        int            i;
        r = '0;
        if (t.run)
        begin
            next_pos = {1'b0, frame_pos} + 17'd1;
            wrapped = next_pos > {1'b0, cfg_shadow[CFG_FRAME_COUNT]};
            frame_pos = wrapped ? 16'd1 : next_pos[15:0];

            // Remainders step by one, or reload to one mod divisor on a wrap.
            for (i = 0; i < NUM_RATES; i++)
            begin
                div_eff = eff_divisor(i);
                if (wrapped)
                    rem_next = (div_eff == 17'd1) ? 17'd0 : 17'd1;
                else if ({1'b0, rate_rem[i]} + 17'd1 >= div_eff)
                    rem_next = 17'd0;
                else
                    rem_next = {1'b0, rate_rem[i]} + 17'd1;
                rate_rem[i] = rem_next[15:0];
                if (rate_rem[i] == 16'd0)
                    r.flags[i] = 1'b1;
            end
            r.mag = ({1'b0, rate_rem[RATE_TEN]} == eff_divisor(RATE_TEN) - 17'd1);

            // Accumulate samples into the saturating sums.
            for (i = 0; i < NUM_AXES; i++)
            begin
                run_sum[SUM_FAST_ACCEL + i] = sat_add(run_sum[SUM_FAST_ACCEL + i], t.smp[i]);
                run_sum[SUM_FAST_GYRO + i]  = sat_add(run_sum[SUM_FAST_GYRO + i],
                                                      t.smp[NUM_AXES + i]);
                run_sum[SUM_SLOW_ACCEL + i] = sat_add(run_sum[SUM_SLOW_ACCEL + i], t.smp[i]);
            end

            // Latch and clear on the fast and medium boundaries.
            if (r.flags[RATE_FAST])
            begin
                for (i = SUM_FAST_ACCEL; i < SUM_SLOW_ACCEL; i++)
                begin
                    latch_sum[i] = run_sum[i];
                    run_sum[i] = '0;
                end
            end
            if (r.flags[RATE_MEDIUM])
            begin
                for (i = SUM_SLOW_ACCEL; i < NUM_SUMS; i++)
                begin
                    latch_sum[i] = run_sum[i];
                    run_sum[i] = '0;
                end
                r.baro = t.temp ? BARO_READ_PRS : BARO_READ_TMP;
            end
        end
        for (i = 0; i < NUM_SUMS; i++)
            r.sums[i] = latch_sum[i];
        return r;
    endfunction

    function automatic tick_req_t random_tick(int run_pct);
        tick_req_t t;
        int i;
        t.run = ($urandom_range(99) < run_pct);
        t.temp = 1'($urandom_range(1));
        for (i = 0; i < 6; i++)
        begin
            case ($urandom_range(15))
                0: t.smp[i] = 16'h7FFF;
                1: t.smp[i] = 16'h8000;
                2: t.smp[i] = 16'h0000;
                3: t.smp[i] = 16'hFFFF;
                default: t.smp[i] = 16'($urandom);
            endcase
        end
        return t;
    endfunction

    function automatic tick_req_t flat_tick(logic [SAMPLE_W-1:0] v, logic temp);
        tick_req_t t;
        int i;
        t.run = 1'b1;
        t.temp = temp;
        for (i = 0; i < 6; i++)
            t.smp[i] = v;
        return t;
    endfunction

    task automatic queue_random(int count, int run_pct);
        int k;
        for (k = 0; k < count; k++)
            tick_backlog.push_back(random_tick(run_pct));
    endtask

    // Wait until every queued request is sent and every result has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (tick_backlog.size() != 0 || tick_bus.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all seven registers in index order; only called while idle.
    task automatic program_schedule(logic [15:0] fc, logic [15:0] d_fast,
                                    logic [15:0] d_medium, logic [15:0] d_fifty,
                                    logic [15:0] d_ten, logic [15:0] d_five,
                                    logic [15:0] d_one);
        logic [15:0] vals [NUM_CFG];
        int i;
        vals = '{fc, d_fast, d_medium, d_fifty, d_ten, d_five, d_one};
        for (i = 0; i < NUM_CFG; i++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i];
            cfg_shadow[i] = vals[i];
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic report_mismatch(string field, logic signed [31:0] want_v,
                                   logic signed [31:0] got_v);
        $display("%0t: result %0d %s expected %0d actual %0d",
                 $time, results_seen, field, want_v, got_v);
        mismatch_count++;
    endtask

    // Tick driver: a new request goes out once the previous one is taken.
    always @(negedge clk)
    begin : tick_driver
        tick_req_t nxt;
        if (rst_n && (!tick_bus.valid || tick_fired))
        begin
            if (tick_backlog.size() != 0 && (steady || $urandom_range(99) >= 24))
            begin
                nxt = tick_backlog.pop_front();
                tick_bus.run_enable <= nxt.run;
                tick_bus.accel_x <= nxt.smp[0];
                tick_bus.accel_y <= nxt.smp[1];
                tick_bus.accel_z <= nxt.smp[2];
                tick_bus.gyro_roll <= nxt.smp[3];
                tick_bus.gyro_pitch <= nxt.smp[4];
                tick_bus.gyro_yaw <= nxt.smp[5];
                tick_bus.temperature_pending <= nxt.temp;
                tick_bus.valid <= 1'b1;
            end
            else
            begin
                tick_bus.valid <= 1'b0;
            end
        end
    end

    // Result backpressure.
    always @(negedge clk)
    begin
        res_bus.ready <= steady || ($urandom_range(99) >= 24);
    end

    // Monitor: predict on each taken tick, check each taken result.
    always @(posedge clk)
    begin : bus_monitor
        tick_req_t     got;
        sched_result_t seen;
        sched_result_t want;
        int            i;
        tick_fired <= tick_bus.valid && tick_bus.ready;
        if (rst_n && tick_bus.valid && tick_bus.ready)
        begin
            got.run = tick_bus.run_enable;
            got.smp = {tick_bus.gyro_yaw, tick_bus.gyro_pitch, tick_bus.gyro_roll,
                       tick_bus.accel_z, tick_bus.accel_y, tick_bus.accel_x};
            got.temp = tick_bus.temperature_pending;
            expected_results.push_back(advance_schedule(got));
        end
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            seen.flags = res_bus.frame_flags;
            seen.baro = baro_action_t'(res_bus.baro_action);
            seen.mag = res_bus.mag_request;
            seen.sums = {res_bus.slow_accel_z, res_bus.slow_accel_y, res_bus.slow_accel_x,
                         res_bus.fast_gyro_yaw, res_bus.fast_gyro_pitch,
                         res_bus.fast_gyro_roll, res_bus.fast_accel_z,
                         res_bus.fast_accel_y, res_bus.fast_accel_x};
            if (expected_results.size() == 0)
            begin
                $display("%0t: result %0d arrived with no tick outstanding",
                         $time, results_seen);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.flags !== want.flags)
                    report_mismatch("frame_flags", 32'(want.flags), 32'(seen.flags));
                if (seen.baro !== want.baro)
                    report_mismatch("baro_action", 32'(want.baro), 32'(seen.baro));
                if (seen.mag !== want.mag)
                    report_mismatch("mag_request", 32'(want.mag), 32'(seen.mag));
                for (i = 0; i < NUM_SUMS; i++)
                begin
                    if (seen.sums[i] !== want.sums[i])
                        report_mismatch(sum_label[i], 32'($signed(want.sums[i])),
                                        32'($signed(seen.sums[i])));
                end
            end
            results_seen++;
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        int k;
        tick_req_t t;

        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_FRAME_COUNT;
        cfg_data = '0;
        tick_bus.valid = 1'b0;
        tick_bus.run_enable = 1'b0;
        tick_bus.accel_x = '0;
        tick_bus.accel_y = '0;
        tick_bus.accel_z = '0;
        tick_bus.gyro_roll = '0;
        tick_bus.gyro_pitch = '0;
        tick_bus.gyro_yaw = '0;
        tick_bus.temperature_pending = 1'b0;
        res_bus.ready = 1'b0;

        cfg_shadow[CFG_FRAME_COUNT] = FRAME_COUNT_RESET;
        for (k = 0; k < NUM_RATES; k++)
        begin
            cfg_shadow[CFG_DIV_FAST + k] = DIV_RESET[k];
            rate_rem[k] = '0;
        end
        for (k = 0; k < NUM_SUMS; k++)
        begin
            run_sum[k] = '0;
            latch_sum[k] = '0;
        end
        frame_pos = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks at the reset settings: sample extremes, disabled ticks,
        // and both temperature flags on a medium boundary.
        for (k = 0; k < 22; k++)
        begin
            case (k % 4)
                0: t = flat_tick(16'h7FFF, k < 12);
                1: t = flat_tick(16'h8000, k < 12);
                2:
                begin
                    t = flat_tick(16'h7FFF, k < 12);
                    t.smp[1] = 16'h8000;
                    t.smp[3] = 16'h8000;
                    t.smp[5] = 16'h8000;
                end
                default:
                begin
                    t = random_tick(100);
                    t.temp = k < 12;
                end
            endcase
            t.run = !(k == 0 || k == 7);
            tick_backlog.push_back(t);
        end
        queue_random(200, 85);
        wait_drained();

        // Short frame with mostly odd divisors.
        program_schedule(16'd50, 16'd3, 16'd7, 16'd11, 16'd25, 16'd40, 16'd49);
        queue_random(250, 85);
        wait_drained();

        // Frame count of zero and divisors of zero and one.
        program_schedule(16'd0, 16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5);
        queue_random(100, 85);
        wait_drained();

        // Full-width frame: saturate the sums at the top, then at the bottom.
        program_schedule(16'hFFFF, 16'd300, 16'd700, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF);
        for (k = 0; k < 300; k++)
            tick_backlog.push_back(flat_tick(16'h7FFF, k[0]));
        for (k = 0; k < 400; k++)
            tick_backlog.push_back(flat_tick(16'h8000, k[0]));
        wait_drained();

        // Small divisors right after large remainders, with no idling.
        steady = 1'b1;
        program_schedule(16'd30, 16'd1, 16'd2, 16'd4, 16'd8, 16'd16, 16'd32);
        queue_random(200, 90);
        wait_drained();
        steady = 1'b0;

        // Random settings.
        for (k = 0; k < 2; k++)
        begin
            program_schedule(16'($urandom_range(200, 1)), 16'($urandom_range(64, 1)),
                             16'($urandom_range(64, 1)), 16'($urandom_range(64, 1)),
                             16'($urandom_range(64, 1)), 16'($urandom_range(64, 1)),
                             16'($urandom_range(64, 1)));
            queue_random(200, 85);
            wait_drained();
        end

        // Frame count of one with mixed extreme divisors.
        program_schedule(16'd1, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 16'd1, 16'd2);
        queue_random(80, 85);
        wait_drained();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
